[rtl/core/oprt_pkg.sv]
// Package for the ordered prefix route table: action and status codes,
// route and sweep item types, and the prefix mask function.
// No dependencies.
`default_nettype none

package oprt_pkg;

  localparam int MAX_ROUTES_DEF = 16;
  localparam int ADDR_W = 32;
  localparam int PLEN_W = 6;
  localparam logic [PLEN_W-1:0] PLEN_MAX = 6'd32;

  typedef enum logic [1:0] {
    ACT_LOOKUP = 2'd0,
    ACT_ADD    = 2'd1,
    ACT_DELETE = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    ST_HIT  = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  typedef struct packed {
    logic [ADDR_W-1:0] dest;
    logic [PLEN_W-1:0] plen;
    logic [ADDR_W-1:0] gw;
  } entry_t;

  // One item travelling down the cell row, with the lookup result so far
  // and a flag that an identical route was already met.
  typedef struct packed {
    logic              valid;
    action_t           action;
    entry_t            key;
    logic              hit;
    logic [PLEN_W-1:0] best_len;
    logic [ADDR_W-1:0] best_hop;
    logic              same;
  } sweep_t;

  function automatic logic [ADDR_W-1:0] prefix_mask(input logic [PLEN_W-1:0] plen);
    prefix_mask = ~({ADDR_W{1'b1}} >> plen);
  endfunction

endpackage

`default_nettype wire

[rtl/core/ordered_prefix_route_table_core.sv]
// Top level of the ordered prefix route table: input register, row of route
// cells, table count, append logic and output register with a skid stage.
// Depends on oprt_pkg and oprt_cell.
`default_nettype none

// Each route sits in one cell of a row of MAX_ROUTES cells, kept in list
// order. An accepted item walks the row one cell per clock; on its way it
// keeps the best lookup match so far, and an add or delete that meets an
// identical route makes that cell and every later one take its neighbor's
// route, closing the gap. An add then writes the new route behind the last
// valid one. The result passes the input register, the cell row and the
// output register. A new item is taken only once the last one has left the
// cell row, and not while a result waits in the skid stage for the output.
module ordered_prefix_route_table_core
  import oprt_pkg::*;
#(
  parameter int MAX_ROUTES = MAX_ROUTES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [71:0] s_tdata,  // dest_addr, prefix_len, gateway, zero fill
  input  wire logic [1:0]  s_tuser,  // action
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [39:0]      m_tdata,  // next_hop, match_len, zero fill
  output logic [1:0]       m_tuser   // status
);

  localparam int CW = $clog2(MAX_ROUTES + 1);

  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic          busy;
  sweep_t        in_q;
  sweep_t        stg [MAX_ROUTES+1];
  entry_t        ent [MAX_ROUTES];

  logic              wr_en;
  logic [CW-1:0]     wr_idx;
  logic [CW-1:0]     c_dec;
  logic              fin;
  status_t           res_status;
  logic [ADDR_W-1:0] res_hop;
  logic [PLEN_W-1:0] res_len;

  logic              skid_valid;
  status_t           skid_status;
  logic [ADDR_W-1:0] skid_hop;
  logic [PLEN_W-1:0] skid_len;
  status_t           out_status;
  logic [ADDR_W-1:0] out_hop;
  logic [PLEN_W-1:0] out_len;
  logic              out_free;
  logic              accept;
  logic [PLEN_W-1:0] in_plen;

  assign s_tready = !busy && !skid_valid;
  assign accept   = s_tvalid && s_tready;
  assign in_plen  = (s_tdata[37:32] > PLEN_MAX) ? PLEN_MAX : s_tdata[37:32];

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q.valid <= 1'b0;
    end else begin
      in_q.valid    <= accept;
      in_q.action   <= action_t'(s_tuser);
      in_q.key.dest <= s_tdata[31:0];
      in_q.key.plen <= in_plen;
      in_q.key.gw   <= s_tdata[69:38];
      in_q.hit      <= 1'b0;
      in_q.best_len <= '0;
      in_q.best_hop <= '0;
      in_q.same     <= 1'b0;
    end
  end

  assign stg[0] = in_q;

  for (genvar i = 0; i < MAX_ROUTES; i++) begin : g_cell
    entry_t nbr;
    if (i == MAX_ROUTES - 1) begin : g_last
      assign nbr = ent[i];
    end else begin : g_mid
      assign nbr = ent[i+1];
    end
    oprt_cell #(
      .IDX (i),
      .CW  (CW)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .count    (count),
      .q_in     (stg[i]),
      .q_out    (stg[i+1]),
      .nbr      (nbr),
      .wr_en    (wr_en),
      .wr_idx   (wr_idx),
      .wr_entry (stg[MAX_ROUTES].key),
      .ent      (ent[i])
    );
  end

  assign fin = stg[MAX_ROUTES].valid;

  always_comb begin
    c_dec      = count - CW'(stg[MAX_ROUTES].same);
    count_next = count;
    wr_en      = 1'b0;
    wr_idx     = c_dec;
    res_status = ST_MISS;
    res_hop    = '0;
    res_len    = '0;
    unique case (stg[MAX_ROUTES].action)
      ACT_LOOKUP: begin
        if (stg[MAX_ROUTES].hit) begin
          res_status = ST_HIT;
          res_hop    = stg[MAX_ROUTES].best_hop;
          res_len    = stg[MAX_ROUTES].best_len;
        end
      end
      ACT_ADD: begin
        if (c_dec < CW'(MAX_ROUTES)) begin
          wr_en      = fin;
          count_next = c_dec + CW'(1);
          res_status = ST_HIT;
        end else begin
          count_next = c_dec;
          res_status = ST_FULL;
        end
      end
      ACT_DELETE: begin
        count_next = c_dec;
        if (stg[MAX_ROUTES].same) begin
          res_status = ST_HIT;
        end
      end
      default: begin
        res_status = ST_MISS;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      busy  <= 1'b0;
    end else begin
      if (fin) begin
        count <= count_next;
        busy  <= 1'b0;
      end else if (accept) begin
        busy <= 1'b1;
      end
    end
  end

  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (out_free) begin
        if (skid_valid) begin
          m_tvalid   <= 1'b1;
          skid_valid <= 1'b0;
        end else begin
          m_tvalid <= fin;
        end
      end else if (fin) begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid) begin
        out_status <= skid_status;
        out_hop    <= skid_hop;
        out_len    <= skid_len;
      end else begin
        out_status <= res_status;
        out_hop    <= res_hop;
        out_len    <= res_len;
      end
    end
    if (fin && !(out_free && !skid_valid)) begin
      skid_status <= res_status;
      skid_hop    <= res_hop;
      skid_len    <= res_len;
    end
  end

  assign m_tdata = {2'b00, out_len, out_hop};
  assign m_tuser = out_status;

endmodule

`default_nettype wire

[rtl/core/oprt_cell.sv]
// One cell of the route row: holds one route and one stage of the sweep.
// Depends on oprt_pkg.
`default_nettype none

module oprt_cell
  import oprt_pkg::*;
#(
  parameter int IDX = 0,
  parameter int CW  = 5
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic [CW-1:0] count,
  input  wire sweep_t        q_in,
  output sweep_t             q_out,
  input  wire entry_t        nbr,
  input  wire logic          wr_en,
  input  wire logic [CW-1:0] wr_idx,
  input  wire entry_t        wr_entry,
  output entry_t             ent
);

  logic   in_range;
  logic   match;
  logic   same_here;
  logic   shift;
  sweep_t q_next;

  always_comb begin
    in_range  = CW'(IDX) < count;
    match     = in_range &&
                (((ent.dest ^ q_in.key.dest) & prefix_mask(ent.plen)) == '0);
    same_here = in_range && (ent == q_in.key);
    shift     = q_in.valid && (q_in.same || same_here) &&
                (q_in.action == ACT_ADD || q_in.action == ACT_DELETE);
    q_next    = q_in;
    q_next.same = q_in.same || same_here;
    if (q_in.action == ACT_LOOKUP && match && (!q_in.hit || ent.plen > q_in.best_len)) begin
      q_next.hit      = 1'b1;
      q_next.best_len = ent.plen;
      q_next.best_hop = ent.gw;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q_out.valid <= 1'b0;
    end else begin
      q_out <= q_next;
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      ent <= nbr;
    end else if (wr_en && wr_idx == CW'(IDX)) begin
      ent <= wr_entry;
    end
  end

endmodule

`default_nettype wire

[tb/route_table_checker.sv]
`timescale 1ns / 1ps
// Checker for ordered_prefix_route_table_core: watches both stream channels,
// keeps its own copy of the route list and compares every result item.
// Depends on oprt_pkg.
module route_table_checker
  import oprt_pkg::*;
#(
  parameter int DEPTH = MAX_ROUTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [71:0] s_tdata,
  input  logic [1:0]  s_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [39:0] m_tdata,
  input  logic [1:0]  m_tuser,
  output int          errors,
  output int          pending,
  output int          checked
);

  typedef struct packed {
    status_t           status;
    logic [ADDR_W-1:0] hop;
    logic [PLEN_W-1:0] len;
  } answer_t;

  entry_t  routes [DEPTH];
  int      route_total;
  answer_t answer_q [$];

  function automatic logic [ADDR_W-1:0] mask_of(input logic [PLEN_W-1:0] plen);
    logic [63:0] wide;
    wide = 64'hFFFF_FFFF << (ADDR_W - plen);
    return wide[ADDR_W-1:0];
  endfunction

  function automatic int find_identical(input entry_t key);
    for (int i = 0; i < route_total; i++) begin
      if (routes[i] == key) return i;
    end
    return -1;
  endfunction

  task automatic remove_route(input int pos);
    for (int i = pos; i + 1 < route_total; i++) routes[i] = routes[i + 1];
    route_total--;
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    $display("mismatch at %0t ns: %s expected 0x%0h got 0x%0h", $time, what, want, got);
    errors++;
  endtask

  task automatic predict_route_answer(input logic [1:0] act, input entry_t req,
                                      output answer_t ans);
    int   pos;
    logic found;
    ans = '{status: ST_MISS, hop: '0, len: '0};
    found = 1'b0;
    if (req.plen > PLEN_MAX) req.plen = PLEN_MAX;
    case (act)
      ACT_LOOKUP: begin
        for (int i = 0; i < route_total; i++) begin
          if (((routes[i].dest ^ req.dest) & mask_of(routes[i].plen)) == '0 &&
              (!found || routes[i].plen > ans.len)) begin
            found = 1'b1;
            ans.len = routes[i].plen;
            ans.hop = routes[i].gw;
          end
        end
        if (found) ans.status = ST_HIT;
      end
      ACT_ADD: begin
        pos = find_identical(req);
        if (pos >= 0) remove_route(pos);
        if (route_total < DEPTH) begin
          routes[route_total] = req;
          route_total++;
          ans.status = ST_HIT;
        end else begin
          ans.status = ST_FULL;
        end
      end
      ACT_DELETE: begin
        pos = find_identical(req);
        if (pos >= 0) begin
          remove_route(pos);
          ans.status = ST_HIT;
        end
      end
      default: begin
      end
    endcase
  endtask

  always @(posedge clk) begin
    answer_t got;
    answer_t want;
    answer_t fresh;
    entry_t  req;
    if (rst) begin
      route_total = 0;
      answer_q.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        got = '{status: status_t'(m_tuser), hop: m_tdata[31:0], len: m_tdata[37:32]};
        checked++;
        if (answer_q.size() == 0) begin
          report_mismatch("result item with nothing expected, status", '0,
                          32'(got.status));
        end else begin
          want = answer_q.pop_front();
          if (got.status != want.status) begin
            report_mismatch("status", 32'(want.status), 32'(got.status));
          end
          if (got.hop != want.hop) report_mismatch("next_hop", want.hop, got.hop);
          if (got.len != want.len) report_mismatch("match_len", 32'(want.len), 32'(got.len));
        end
      end
      if (s_tvalid && s_tready) begin
        req.dest = s_tdata[31:0];
        req.plen = s_tdata[37:32];
        req.gw   = s_tdata[69:38];
        predict_route_answer(s_tuser, req, fresh);
        answer_q.insert(answer_q.size(), fresh);
      end
    end
    pending = answer_q.size();
  end

endmodule

[tb/ordered_prefix_route_table_core_tb.sv]
`timescale 1ns / 1ps
// Testbench top for ordered_prefix_route_table_core: drives directed and
// random route items with random idling and gives the verdict.
// Depends on oprt_pkg, route_table_checker and the block itself.
module ordered_prefix_route_table_core_tb;
  import oprt_pkg::*;

  localparam int         DEPTH        = MAX_ROUTES_DEF;
  localparam int         RANDOM_ITEMS = 730;
  localparam int         QUIET_TAIL   = 120;
  localparam int         STALL_LIMIT  = 2000;
  localparam logic [1:0] ACT_UNUSED   = 2'd3;
  localparam logic [31:0] LEAD_BYTES  = 32'h0AC0_ACFF;
  localparam logic [47:0] PLEN_MENU   = {6'd0, 6'd8, 6'd12, 6'd16, 6'd20, 6'd24, 6'd28, 6'd32};

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [71:0] s_tdata;  // dest_addr, prefix_len, gateway, zero fill
  logic [1:0]  s_tuser;  // action
  logic        m_tvalid;
  logic        m_tready;
  logic [39:0] m_tdata;  // next_hop, match_len, zero fill
  logic [1:0]  m_tuser;  // status

  int     errors;
  int     pending;
  int     checked;
  int     quiet_cycles;
  int     sent [4];
  bit     idle_on;
  entry_t pool [$];

  ordered_prefix_route_table_core #(
    .MAX_ROUTES(DEPTH)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser)
  );

  route_table_checker #(
    .DEPTH(DEPTH)
  ) u_checker (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser),
    .errors(errors),
    .pending(pending),
    .checked(checked)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    m_tready = 1'b0;
    @(negedge clk);
    forever begin
      if (idle_on && $urandom_range(0, 4) == 0) begin
        m_tready = 1'b0;
        repeat ($urandom_range(1, 3)) @(negedge clk);
      end
      m_tready = 1'b1;
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAIL ordered_prefix_route_table_core");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_item(input logic [1:0] act, input logic [31:0] dest,
                           input logic [5:0] plen, input logic [31:0] gw);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_tvalid = 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tuser  = act;
    s_tdata  = {2'b00, gw, plen, dest};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sent[act]++;
    @(negedge clk);
  endtask

  task automatic make_route(input bit reuse, output entry_t r);
    if (reuse && pool.size() != 0) begin
      r = pool[$urandom_range(0, pool.size() - 1)];
    end else begin
      r.dest = {LEAD_BYTES[8 * $urandom_range(0, 3) +: 8],
                ($urandom_range(0, 1) != 0) ? 8'h01 : 8'($urandom()), 16'($urandom())};
      r.plen = ($urandom_range(0, 7) == 0) ? 6'($urandom_range(0, 63))
                                           : PLEN_MENU[6 * $urandom_range(0, 7) +: 6];
      r.gw   = $urandom();
      pool.insert(pool.size(), r);
      if (pool.size() > 40) void'(pool.pop_front());
    end
    if (r.plen >= PLEN_MAX && $urandom_range(0, 1) != 0) r.plen = 6'($urandom_range(32, 63));
  endtask

  initial begin
    int          phase;
    int          pick;
    int          add_cut;
    int          del_cut;
    entry_t      r;
    logic [31:0] look;
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tuser  = ACT_LOOKUP;
    idle_on  = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed items: empty table, default route, nesting, ties, duplicate
    // add moving to the tail, length saturation and the unused action.
    idle_on = 1'b1;
    send_item(ACT_LOOKUP, 32'hC0A8_0101, 6'd0, 32'h0);
    send_item(ACT_DELETE, 32'h0A00_0000, 6'd8, 32'h0101_0101);
    send_item(ACT_ADD, 32'h0000_0000, 6'd0, 32'h0A0A_0A01);
    send_item(ACT_LOOKUP, 32'hFFFF_FFFF, 6'd0, 32'h0);
    send_item(ACT_ADD, 32'h0A00_0000, 6'd8, 32'h0A00_0001);
    send_item(ACT_ADD, 32'h0A01_0000, 6'd16, 32'h0A01_0001);
    send_item(ACT_ADD, 32'h0A01_0203, 6'd32, 32'hFFFF_FFFF);
    send_item(ACT_LOOKUP, 32'h0A01_0203, 6'd0, 32'h0);
    send_item(ACT_LOOKUP, 32'h0A01_0909, 6'd0, 32'h0);
    send_item(ACT_LOOKUP, 32'h0AFF_0000, 6'd0, 32'h0);
    send_item(ACT_ADD, 32'h0A01_7777, 6'd16, 32'h0A01_0002);
    send_item(ACT_LOOKUP, 32'h0A01_0505, 6'd0, 32'h0);
    send_item(ACT_ADD, 32'h0A01_0000, 6'd16, 32'h0A01_0001);
    send_item(ACT_LOOKUP, 32'h0A01_0505, 6'd0, 32'h0);
    send_item(ACT_ADD, 32'hFFFF_FFFF, 6'd63, 32'h0);
    send_item(ACT_LOOKUP, 32'hFFFF_FFFF, 6'd0, 32'h0);
    send_item(ACT_DELETE, 32'hFFFF_FFFF, 6'd33, 32'h0);
    send_item(ACT_DELETE, 32'hFFFF_FFFF, 6'd32, 32'h0);
    send_item(ACT_UNUSED, 32'hFFFF_FFFF, 6'h3F, 32'hFFFF_FFFF);
    send_item(ACT_DELETE, 32'h0000_0000, 6'd0, 32'h0A0A_0A01);
    send_item(ACT_LOOKUP, 32'hC0A8_0101, 6'd0, 32'h0);

    // Random items in phases that fill the table past full, mix, and drain.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      phase   = (n / 80) % 3;
      idle_on = (n < RANDOM_ITEMS - QUIET_TAIL) && ((n / 50) % 4 != 3);
      if (n == RANDOM_ITEMS / 2) begin
        s_tvalid = 1'b0;
        while (pending != 0) @(negedge clk);
      end
      add_cut = (phase == 0) ? 65 : (phase == 1) ? 35 : 15;
      del_cut = (phase == 0) ? 75 : 55;
      pick    = $urandom_range(0, 99);
      if ($urandom_range(0, 49) == 0) begin
        send_item(ACT_UNUSED, $urandom(), 6'($urandom()), $urandom());
      end else if (pick < add_cut) begin
        make_route($urandom_range(0, 2) == 0, r);
        send_item(ACT_ADD, r.dest, r.plen, r.gw);
      end else if (pick < del_cut) begin
        if ($urandom_range(0, 4) != 0) begin
          make_route(1'b1, r);
        end else begin
          r.dest = $urandom();
          r.plen = 6'($urandom_range(0, 63));
          r.gw   = $urandom();
        end
        send_item(ACT_DELETE, r.dest, r.plen, r.gw);
      end else begin
        if (pool.size() != 0 && $urandom_range(0, 3) != 0) begin
          r    = pool[$urandom_range(0, pool.size() - 1)];
          look = r.dest ^ ($urandom() >> r.plen);
        end else begin
          look = $urandom();
        end
        send_item(ACT_LOOKUP, look, 6'($urandom()), $urandom());
      end
    end
    s_tvalid = 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (DEPTH + 4) @(posedge clk);
    $display("Covered %0d lookups, %0d adds, %0d deletes and %0d unused-action items.",
             sent[ACT_LOOKUP], sent[ACT_ADD], sent[ACT_DELETE], sent[ACT_UNUSED]);
    $display("Compared %0d result items against the predicted route list.", checked);
    if (errors == 0) begin
      $display("PASS ordered_prefix_route_table_core");
    end else begin
      $display("FAIL ordered_prefix_route_table_core");
    end
    $finish;
  end

endmodule
